// File: rtl/core/ppm_dec_pkg.sv
// Shared types, codes and helper functions of the P6 stream decoder.
package ppm_dec_pkg;

  localparam int unsigned MaxSideDef = 4096;
  localparam int unsigned SideOutW   = 13;
  localparam int unsigned NumW       = 16;
  localparam int unsigned NumProdW   = 20;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);
  localparam logic [3:0]  ShortLen   = 4'd8;
  localparam logic [NumProdW-1:0] NumLimit = NumProdW'(65535);
  localparam logic [NumW-1:0]     MaxvalLimit = NumW'(256);
  localparam logic [7:0]  AlphaOpaque = 8'd255;

  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] Ch6    = 8'h36;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChNl   = 8'h0A;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChCr   = 8'h0D;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindPixel  = 2'd1,
    KindStatus = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StTooBig  = 2'd2
  } status_e;

  typedef enum logic [10:0] {
    PhMagic0 = 11'b000_0000_0001,
    PhMagic1 = 11'b000_0000_0010,
    PhSkipW  = 11'b000_0000_0100,
    PhNumW   = 11'b000_0000_1000,
    PhSkipH  = 11'b000_0001_0000,
    PhNumH   = 11'b000_0010_0000,
    PhSkipM  = 11'b000_0100_0000,
    PhNumM   = 11'b000_1000_0000,
    PhPixels = 11'b001_0000_0000,
    PhDone   = 11'b010_0000_0000,
    PhError  = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e                kind;
    logic [SideOutW-1:0]  width;
    logic [SideOutW-1:0]  height;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    status_e              status;
    logic                 last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSp) || (b >= ChTab && b <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= Ch0) && (b <= Ch9);
  endfunction

endpackage

// File: rtl/core/ppm_dec_if.sv
// Stream interfaces: file bytes in, decoded results out.
interface ppm_dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ppm_dec_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] width;
  logic [12:0] height;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output kind, output width, output height, output red,
                  output green, output blue, output alpha, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input width, input height, input red,
                  input green, input blue, input alpha, input status,
                  input last_of_run, output ready);
endinterface

// File: rtl/core/ppm_dec_core.sv
// Per-byte header parser and pixel assembler; yields up to two results per byte.
module ppm_dec_core #(
  parameter int unsigned MaxSide = ppm_dec_pkg::MaxSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output ppm_dec_pkg::push_t  push_o
);

  localparam int unsigned SideW = $clog2(MaxSide + 1);
  localparam int unsigned PixW  = 2 * SideW;
  localparam logic [ppm_dec_pkg::NumW-1:0] MaxSideV = ppm_dec_pkg::NumW'(MaxSide);

  ppm_dec_pkg::phase_e  ph_q, ph_d;
  ppm_dec_pkg::status_e err_q, err_d;
  logic                          cmt_q, cmt_d;
  logic [ppm_dec_pkg::NumW-1:0]  num_q, num_d;
  logic [ppm_dec_pkg::NumW-1:0]  w_q, w_d;
  logic [ppm_dec_pkg::NumW-1:0]  h_q, h_d;
  logic [PixW-1:0]               pix_q, pix_d;
  logic [1:0]                    bip_q, bip_d;
  logic [7:0]                    red_q, red_d;
  logic [7:0]                    green_q, green_d;
  logic [3:0]                    cnt_q, cnt_d;

  logic                          sk_en, sk_cmt;
  ppm_dec_pkg::phase_e           sk_num;
  logic [ppm_dec_pkg::NumProdW-1:0] acc;
  logic [PixW-1:0]               pix_dec;
  logic                          fail;
  ppm_dec_pkg::status_e          fail_code, fin_st;
  ppm_dec_pkg::res_t             main_res, stat_res;
  logic                          main_en;

  assign acc = ppm_dec_pkg::NumProdW'(num_q) * ppm_dec_pkg::NumProdW'(10)
             + ppm_dec_pkg::NumProdW'(data_byte_i - ppm_dec_pkg::Ch0);
  assign pix_dec = (pix_q != '0) ? pix_q - PixW'(1) : pix_q;

  always_comb begin
    ph_d      = ph_q;
    err_d     = err_q;
    cmt_d     = cmt_q;
    num_d     = num_q;
    w_d       = w_q;
    h_d       = h_q;
    pix_d     = pix_q;
    bip_d     = bip_q;
    red_d     = red_q;
    green_d   = green_q;
    cnt_d     = (cnt_q < ppm_dec_pkg::ShortLen) ? cnt_q + 4'd1 : cnt_q;
    sk_en     = 1'b0;
    sk_cmt    = cmt_q;
    sk_num    = ppm_dec_pkg::PhNumW;
    fail      = 1'b0;
    fail_code = ppm_dec_pkg::StInvalid;
    main_en   = 1'b0;
    main_res  = '0;

    unique case (ph_q) inside
      ppm_dec_pkg::PhMagic0: begin
        if (data_byte_i == ppm_dec_pkg::ChP) ph_d = ppm_dec_pkg::PhMagic1;
        else fail = 1'b1;
      end
      ppm_dec_pkg::PhMagic1: begin
        if (data_byte_i == ppm_dec_pkg::Ch6) begin
          ph_d  = ppm_dec_pkg::PhSkipW;
          cmt_d = 1'b0;
        end else begin
          fail = 1'b1;
        end
      end
      ppm_dec_pkg::PhSkipW: begin
        sk_en  = 1'b1;
        sk_num = ppm_dec_pkg::PhNumW;
      end
      ppm_dec_pkg::PhSkipH: begin
        sk_en  = 1'b1;
        sk_num = ppm_dec_pkg::PhNumH;
      end
      ppm_dec_pkg::PhSkipM: begin
        sk_en  = 1'b1;
        sk_num = ppm_dec_pkg::PhNumM;
      end
      ppm_dec_pkg::PhNumW, ppm_dec_pkg::PhNumH: begin
        if (ppm_dec_pkg::is_digit(data_byte_i)) begin
          if (acc > ppm_dec_pkg::NumLimit) fail = 1'b1;
          else num_d = acc[ppm_dec_pkg::NumW-1:0];
        end else begin
          // close the number, then treat this byte as separator
          if (ph_q == ppm_dec_pkg::PhNumW) begin
            w_d    = num_q;
            ph_d   = ppm_dec_pkg::PhSkipH;
            sk_num = ppm_dec_pkg::PhNumH;
          end else begin
            h_d    = num_q;
            ph_d   = ppm_dec_pkg::PhSkipM;
            sk_num = ppm_dec_pkg::PhNumM;
          end
          sk_en  = 1'b1;
          sk_cmt = 1'b0;
        end
      end
      ppm_dec_pkg::PhNumM: begin
        if (ppm_dec_pkg::is_digit(data_byte_i)) begin
          if (acc > ppm_dec_pkg::NumLimit) fail = 1'b1;
          else num_d = acc[ppm_dec_pkg::NumW-1:0];
        end else if (w_q == '0 || h_q == '0 || w_q > MaxSideV || h_q > MaxSideV) begin
          fail      = 1'b1;
          fail_code = ppm_dec_pkg::StTooBig;
        end else if (num_q == '0 || num_q >= ppm_dec_pkg::MaxvalLimit) begin
          fail = 1'b1;
        end else if (!ppm_dec_pkg::is_space(data_byte_i)) begin
          fail = 1'b1;
        end else begin
          main_en        = 1'b1;
          main_res.kind  = ppm_dec_pkg::KindHeader;
          main_res.width = w_q[ppm_dec_pkg::SideOutW-1:0];
          main_res.height = h_q[ppm_dec_pkg::SideOutW-1:0];
          pix_d = PixW'(w_q[SideW-1:0]) * PixW'(h_q[SideW-1:0]);
          bip_d = 2'd0;
          ph_d  = ppm_dec_pkg::PhPixels;
        end
      end
      ppm_dec_pkg::PhPixels: begin
        case (bip_q)
          2'd0: begin
            red_d = data_byte_i;
            bip_d = 2'd1;
          end
          2'd1: begin
            green_d = data_byte_i;
            bip_d   = 2'd2;
          end
          default: begin
            main_en        = 1'b1;
            main_res.kind  = ppm_dec_pkg::KindPixel;
            main_res.red   = red_q;
            main_res.green = green_q;
            main_res.blue  = data_byte_i;
            main_res.alpha = ppm_dec_pkg::AlphaOpaque;
            bip_d = 2'd0;
            pix_d = pix_dec;
            if (pix_dec == '0) ph_d = ppm_dec_pkg::PhDone;
          end
        endcase
      end
      ppm_dec_pkg::PhDone, ppm_dec_pkg::PhError: begin
      end
      default: begin
      end
    endcase

    // whitespace and comment skipping ahead of a number
    if (sk_en) begin
      if (sk_cmt) begin
        if (data_byte_i == ppm_dec_pkg::ChNl) cmt_d = 1'b0;
      end else if (ppm_dec_pkg::is_space(data_byte_i)) begin
        cmt_d = 1'b0;
      end else if (data_byte_i == ppm_dec_pkg::ChHash) begin
        cmt_d = 1'b1;
      end else if (ppm_dec_pkg::is_digit(data_byte_i)) begin
        cmt_d = 1'b0;
        num_d = ppm_dec_pkg::NumW'(data_byte_i - ppm_dec_pkg::Ch0);
        ph_d  = sk_num;
      end else begin
        fail = 1'b1;
      end
    end

    if (fail) begin
      err_d = fail_code;
      ph_d  = ppm_dec_pkg::PhError;
    end

    if (cnt_d < ppm_dec_pkg::ShortLen)   fin_st = ppm_dec_pkg::StInvalid;
    else if (err_d != ppm_dec_pkg::StOk) fin_st = err_d;
    else if (ph_d != ppm_dec_pkg::PhDone) fin_st = ppm_dec_pkg::StInvalid;
    else                                  fin_st = ppm_dec_pkg::StOk;

    stat_res             = '0;
    stat_res.kind        = ppm_dec_pkg::KindStatus;
    stat_res.status      = fin_st;
    stat_res.last_of_run = 1'b1;

    push_o = '0;
    if (main_en) begin
      push_o.r0 = main_res;
      if (final_byte_i) begin
        push_o.cnt = 2'd2;
        push_o.r1  = stat_res;
      end else begin
        push_o.cnt            = 2'd1;
        push_o.r0.last_of_run = 1'b1;
      end
    end else if (final_byte_i) begin
      push_o.cnt = 2'd1;
      push_o.r0  = stat_res;
    end
    if (!fire_i) push_o.cnt = 2'd0;

    // status closes the file: back to reset for the next one
    if (final_byte_i) begin
      ph_d    = ppm_dec_pkg::PhMagic0;
      err_d   = ppm_dec_pkg::StOk;
      cmt_d   = 1'b0;
      num_d   = '0;
      w_d     = '0;
      h_d     = '0;
      pix_d   = '0;
      bip_d   = 2'd0;
      red_d   = '0;
      green_d = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= ppm_dec_pkg::PhMagic0;
      err_q   <= ppm_dec_pkg::StOk;
      cmt_q   <= 1'b0;
      num_q   <= '0;
      w_q     <= '0;
      h_q     <= '0;
      pix_q   <= '0;
      bip_q   <= 2'd0;
      red_q   <= '0;
      green_q <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      ph_q    <= ph_d;
      err_q   <= err_d;
      cmt_q   <= cmt_d;
      num_q   <= num_d;
      w_q     <= w_d;
      h_q     <= h_d;
      pix_q   <= pix_d;
      bip_q   <= bip_d;
      red_q   <= red_d;
      green_q <= green_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/core/ppm_dec_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
module ppm_dec_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ppm_dec_pkg::push_t                  push_i,
  input  logic                                pop_i,
  output ppm_dec_pkg::res_t                   head_o,
  output logic [ppm_dec_pkg::FifoCntW-1:0]    count_o
);

  ppm_dec_pkg::res_t                  mem_q [ppm_dec_pkg::FifoDepth];
  logic [ppm_dec_pkg::FifoPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ppm_dec_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic [ppm_dec_pkg::FifoPtrW-1:0]   wptr_nx;

  assign wptr_nx = wptr_q + ppm_dec_pkg::FifoPtrW'(1);
  assign wptr_d  = wptr_q + ppm_dec_pkg::FifoPtrW'(push_i.cnt);
  assign rptr_d  = rptr_q + ppm_dec_pkg::FifoPtrW'(pop_i);
  assign cnt_d   = cnt_q + ppm_dec_pkg::FifoCntW'(push_i.cnt)
                 - ppm_dec_pkg::FifoCntW'(pop_i);
  assign head_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wptr_nx] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: rtl/core/ppm_p6_stream_decoder.sv
// Top level of the streaming binary PPM (P6) decoder.
// Takes one file byte per cycle while ready: each byte is parsed and its results
// are written to a four-entry result queue in the cycle of its transfer, so they
// can show at the output in the cycle after, behind any results still queued. The
// input is ready while the queue holds at most two results. A byte that completes
// a pixel and is also marked final yields two results (pixel, then status); the
// single-result output port then hands them out one after the other.
// Results: a header with width and height, one RGBA pixel per three data bytes,
// then a status on the final byte. Pixels leave before the status is known; drop
// them when the status is not ok. After the status the decoder expects a new file.
module ppm_p6_stream_decoder #(
  parameter int unsigned MaxSide = ppm_dec_pkg::MaxSideDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppm_dec_byte_if.sink          byte_i,
  ppm_dec_res_if.source         res_o
);

  ppm_dec_pkg::push_t                push;
  ppm_dec_pkg::res_t                 head;
  logic [ppm_dec_pkg::FifoCntW-1:0]  count;
  logic                              fire, pop;

  assign byte_i.ready = (count <= ppm_dec_pkg::FifoCntW'(ppm_dec_pkg::FifoDepth - 2));
  assign fire         = byte_i.valid && byte_i.ready;
  assign res_o.valid  = (count != '0);
  assign pop          = res_o.valid && res_o.ready;

  ppm_dec_core #(
    .MaxSide (MaxSide)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (byte_i.data_byte),
    .final_byte_i (byte_i.final_byte),
    .push_o       (push)
  );

  ppm_dec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign res_o.kind        = head.kind;
  assign res_o.width       = head.width;
  assign res_o.height      = head.height;
  assign res_o.red         = head.red;
  assign res_o.green       = head.green;
  assign res_o.blue        = head.blue;
  assign res_o.alpha       = head.alpha;
  assign res_o.status      = head.status;
  assign res_o.last_of_run = head.last_of_run;

endmodule

// File: rtl/core/ppm_dec_chk.sv
// Port-level checks of the P6 decoder, bound to its top level.
module ppm_dec_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_final_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  logic [7:0]  out_alpha_i,
  input  logic        out_last_i
);

  // hold a result until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> out_valid_i)
    else $error("final byte gave no result");

  a_pixel_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == ppm_dec_pkg::KindPixel |-> out_alpha_i == 8'd255)
    else $error("pixel alpha not opaque");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == ppm_dec_pkg::KindStatus |-> out_last_i)
    else $error("status not marked last of run");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_kind_i != 2'd3)
    else $error("undefined result kind");

endmodule

bind ppm_p6_stream_decoder ppm_dec_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .in_final_i  (byte_i.final_byte),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kind_i  (res_o.kind),
  .out_alpha_i (res_o.alpha),
  .out_last_i  (res_o.last_of_run)
);
